[sv/bpd_pkg.sv]
// ----------------------------------------------------------------------------
// Byte pair decoder package
// Shared constants, types and control structures of the byte pair decoder.
// ----------------------------------------------------------------------------
package bpd_pkg;

   // Largest pair count that a header may announce.
   localparam int MAX_PAIRS     = 127;
   // Largest number of literals that one pair may expand to.
   localparam int MAX_EXPANSION = 64;

   localparam int PAIR_DEPTH    = 128;
   localparam int PAIR_AW       = $clog2(PAIR_DEPTH);
   localparam int STACK_DEPTH   = 64;
   localparam int STACK_AW      = $clog2(STACK_DEPTH);
   // The stack pointer also holds the full depth.
   localparam int SP_W          = STACK_AW + 1;
   // Expansion lengths run from 1 to MAX_EXPANSION.
   localparam int LEN_W         = 7;

   typedef logic [7:0]          symbol_type;
   typedef logic [6:0]          literal_type;
   typedef logic [PAIR_AW-1:0]  pair_addr_type;
   typedef logic [STACK_AW-1:0] stack_addr_type;
   typedef logic [SP_W-1:0]     stack_ptr_type;
   typedef logic [LEN_W-1:0]    length_type;
   typedef logic [15:0]         pair_word_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_FWD_REF    = 2'd2,
      STATUS_TOO_LONG   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_TABLE  = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP,
      ST_SPLIT,
      ST_FETCH,
      ST_ERROR
   } state_type;

   // Control from the sequencer to the pair table and length store.
   typedef struct packed {
      logic          wr_en;
      pair_addr_type wr_addr;
      pair_word_type wr_pair;
      length_type    wr_len;
      pair_addr_type pair_rd_addr;
      pair_addr_type len_rd_addr;
   } pstore_ctl_type;

   // Control from the sequencer to the expansion stack.
   typedef struct packed {
      logic           wr_en;
      stack_addr_type wr_addr;
      symbol_type     wr_data;
      stack_addr_type rd_addr;
   } stack_ctl_type;

endpackage

[sv/bpd_req_if.sv]
// ----------------------------------------------------------------------------
// Byte pair decoder input channel
// Valid/ready channel carrying one byte of the compressed file per transfer.
// ----------------------------------------------------------------------------
interface bpd_req_if import bpd_pkg::*; ();

   logic       valid;
   logic       ready;
   symbol_type in_byte;
   logic       file_start;

   modport source (output valid, output in_byte, output file_start, input ready);
   modport sink   (input valid, input in_byte, input file_start, output ready);

endinterface

[sv/bpd_rsp_if.sv]
// ----------------------------------------------------------------------------
// Byte pair decoder result channel
// Valid/ready channel carrying one decoded literal or error per transfer.
// ----------------------------------------------------------------------------
interface bpd_rsp_if import bpd_pkg::*; ();

   logic        valid;
   logic        ready;
   literal_type out_byte;
   logic        last;
   logic [1:0]  status;

   modport source (output valid, output out_byte, output last, output status, input ready);
   modport sink   (input valid, input out_byte, input last, input status, output ready);

endinterface

[sv/bpd_pair_store.sv]
// ----------------------------------------------------------------------------
// Byte pair decoder pair store
// Pair table and expansion length memories, one write port and one
// registered read port each.
// ----------------------------------------------------------------------------
module bpd_pair_store import bpd_pkg::*; (
   input  logic           clock,
   input  pstore_ctl_type ctl,
   output pair_word_type  pair_rd,
   output length_type     len_rd
);

   pair_word_type pair_mem [PAIR_DEPTH];
   length_type    len_mem  [PAIR_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         pair_mem[ctl.wr_addr] <= ctl.wr_pair;
         len_mem[ctl.wr_addr]  <= ctl.wr_len;
      end
      pair_rd <= pair_mem[ctl.pair_rd_addr];
      len_rd  <= len_mem[ctl.len_rd_addr];
   end

endmodule

[sv/bpd_stack_mem.sv]
// ----------------------------------------------------------------------------
// Byte pair decoder expansion stack
// Symbol memory behind the expansion stack, one write and one registered read.
// ----------------------------------------------------------------------------
module bpd_stack_mem import bpd_pkg::*; (
   input  logic          clock,
   input  stack_ctl_type ctl,
   output symbol_type    rd_data
);

   symbol_type mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data <= mem[ctl.rd_addr];
   end

endmodule

[sv/byte_pair_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Byte pair decoder unit
// Decodes byte pair encoded files one input byte at a time.
// ----------------------------------------------------------------------------
// The unit takes one byte per input transfer and handles it fully before it
// takes the next one. Header and pair table bytes pass through the decode
// state, a literal data byte also through the pop state, where it may wait
// on the result channel. A pair code is expanded depth first by one sequencer
// working on a stack memory: each literal of the run takes a pop and a fetch
// state and each inner pair a pop and a split state, since the reads of the
// pair table and the stack are single-port and registered. One result register
// sits on the output, so a result may wait there while the sequencer works
// on. A file starts with a header byte equal to the pair count plus 128,
// followed by two symbols per pair and then data. Errors (bad header, forward
// pair reference, expansion longer than 64 literals) give one result with
// status set, byte 0 and last set; after that every byte is dropped until a
// byte with file_start arrives. Data codes naming undefined pairs give no
// result. Stores need no clearing after reset, so the unit is ready right away.
// ----------------------------------------------------------------------------
module byte_pair_decoder_unit import bpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bpd_req_if.sink    req_ch,
   bpd_rsp_if.source  rsp_ch
);

   // Sequencer and decode state.
   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   literal_type   pair_count_ff, pair_count_in;
   literal_type   table_index_ff, table_index_in;
   logic          second_half_ff, second_half_in;
   symbol_type    held_symbol_ff, held_symbol_in;
   length_type    held_len_ff, held_len_in;
   logic          failed_ff, failed_in;
   symbol_type    byte_ff, byte_in;
   symbol_type    top_ff, top_in;
   stack_ptr_type sp_ff, sp_in;
   status_type    err_ff, err_in;

   // Result register.
   logic          rsp_valid_ff;
   literal_type   rsp_byte_ff;
   logic          rsp_last_ff;
   status_type    rsp_status_ff;

   logic          emit;
   literal_type   emit_byte;
   logic          emit_last;
   status_type    emit_status;
   logic          out_free;

   pstore_ctl_type pstore_ctl;
   stack_ctl_type  stack_ctl;
   pair_word_type  pair_rd;
   length_type     len_rd;
   symbol_type     stack_rd;

   length_type    sym_len;
   logic [7:0]    len_sum;
   literal_type   index_next;

   bpd_pair_store u_pair_store (
      .clock   (clock),
      .ctl     (pstore_ctl),
      .pair_rd (pair_rd),
      .len_rd  (len_rd)
   );

   bpd_stack_mem u_stack (
      .clock   (clock),
      .ctl     (stack_ctl),
      .rd_data (stack_rd)
   );

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.last     = rsp_last_ff;
   assign rsp_ch.status   = rsp_status_ff;

   // The result register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // The length of the latched symbol was read from the store during the
   // accepting cycle, so it is on hand in the decode cycle.
   assign sym_len    = byte_ff[7] ? len_rd : length_type'(1);
   assign len_sum    = {1'b0, held_len_ff} + {1'b0, sym_len};
   assign index_next = table_index_ff + 7'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_HEADER;
         pair_count_ff  <= '0;
         table_index_ff <= '0;
         second_half_ff <= 1'b0;
         held_symbol_ff <= '0;
         failed_ff      <= 1'b0;
         sp_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         pair_count_ff  <= pair_count_in;
         table_index_ff <= table_index_in;
         second_half_ff <= second_half_in;
         held_symbol_ff <= held_symbol_in;
         failed_ff      <= failed_in;
         sp_ff          <= sp_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      held_len_ff <= held_len_in;
      byte_ff     <= byte_in;
      top_ff      <= top_in;
      err_ff      <= err_in;
      if (emit) begin
         rsp_byte_ff   <= emit_byte;
         rsp_last_ff   <= emit_last;
         rsp_status_ff <= emit_status;
      end
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      pair_count_in  = pair_count_ff;
      table_index_in = table_index_ff;
      second_half_in = second_half_ff;
      held_symbol_in = held_symbol_ff;
      held_len_in    = held_len_ff;
      failed_in      = failed_ff;
      byte_in        = byte_ff;
      top_in         = top_ff;
      sp_in          = sp_ff;
      err_in         = err_ff;

      emit        = 1'b0;
      emit_byte   = top_ff[6:0];
      emit_last   = (sp_ff == '0);
      emit_status = STATUS_OK;

      // Pair reads track the sequencer, length reads the input; stores read every cycle.
      pstore_ctl.wr_en        = 1'b0;
      pstore_ctl.wr_addr      = table_index_ff;
      pstore_ctl.wr_pair      = {held_symbol_ff, byte_ff};
      pstore_ctl.wr_len       = len_sum[LEN_W-1:0];
      pstore_ctl.pair_rd_addr = top_ff[6:0];
      pstore_ctl.len_rd_addr  = req_ch.in_byte[6:0];

      // The stack read always looks at the entry just below the pointer.
      stack_ctl.wr_en   = 1'b0;
      stack_ctl.wr_addr = sp_ff[STACK_AW-1:0];
      stack_ctl.wr_data = pair_rd[7:0];
      stack_ctl.rd_addr = sp_ff[STACK_AW-1:0] - 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               byte_in = req_ch.in_byte;
               if (req_ch.file_start) begin
                  failed_in = 1'b0;
                  phase_in  = PH_HEADER;
               end
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            if (!failed_ff) begin
               case (phase_ff)
                  PH_HEADER: begin
                     if (!byte_ff[7] || (byte_ff[6:0] > 7'(MAX_PAIRS))) begin
                        err_in   = STATUS_BAD_HEADER;
                        state_in = ST_ERROR;
                     end else begin
                        pair_count_in  = byte_ff[6:0];
                        table_index_in = '0;
                        second_half_in = 1'b0;
                        held_symbol_in = '0;
                        phase_in       = (byte_ff[6:0] == '0) ? PH_DATA : PH_TABLE;
                     end
                  end
                  PH_TABLE: begin
                     // A symbol may only name a pair defined before this one.
                     if (byte_ff[7] && (byte_ff[6:0] >= table_index_ff)) begin
                        err_in   = STATUS_FWD_REF;
                        state_in = ST_ERROR;
                     end else if (!second_half_ff) begin
                        held_symbol_in = byte_ff;
                        held_len_in    = sym_len;
                        second_half_in = 1'b1;
                     end else if (len_sum > 8'(MAX_EXPANSION)) begin
                        err_in   = STATUS_TOO_LONG;
                        state_in = ST_ERROR;
                     end else begin
                        pstore_ctl.wr_en = 1'b1;
                        second_half_in   = 1'b0;
                        table_index_in   = index_next;
                        if (index_next >= pair_count_ff) begin
                           phase_in = PH_DATA;
                        end
                     end
                  end
                  PH_DATA: begin
                     // Codes of undefined pairs are dropped without a result.
                     if (!byte_ff[7] || (byte_ff[6:0] < pair_count_ff)) begin
                        top_in   = byte_ff;
                        sp_in    = '0;
                        state_in = ST_POP;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_POP: begin
            if (!top_ff[7]) begin
               // A literal on top: send it, then take the next stack entry.
               // It ends the run when the stack below it is empty.
               if (out_free) begin
                  emit = 1'b1;
                  if (sp_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     sp_in    = sp_ff - 1'b1;
                     state_in = ST_FETCH;
                  end
               end
            end else begin
               // A pair on top: its two symbols arrive from the table next cycle.
               state_in = ST_SPLIT;
            end
         end

         ST_SPLIT: begin
            // The second symbol goes on the stack, the first becomes the top.
            stack_ctl.wr_en = 1'b1;
            sp_in           = sp_ff + 1'b1;
            top_in          = pair_rd[15:8];
            state_in        = ST_POP;
         end

         ST_FETCH: begin
            top_in   = stack_rd;
            state_in = ST_POP;
         end

         ST_ERROR: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_byte   = '0;
               emit_last   = 1'b1;
               emit_status = err_ff;
               failed_in   = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // The stack never holds more entries than its memory has.
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff < stack_ptr_type'(STACK_DEPTH))
      else $error("expansion stack pointer out of range");

   // An error result carries a zero byte and ends the results of its byte.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |-> (rsp_byte_ff == '0) && rsp_last_ff)
      else $error("error result with payload");

   // A split always follows the pop of a pair code.
   a_split_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SPLIT |-> ($past(state_ff) == ST_POP) && $past(top_ff[7]))
      else $error("split without a popped pair");

   // Only defined pairs are ever expanded, and only in the data phase.
   a_defined_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) && top_ff[7] |-> (top_ff[6:0] < pair_count_ff) &&
                                            (phase_ff == PH_DATA))
      else $error("expansion of an undefined pair");
`endif

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Byte pair decoder unit testbench
// Sends compressed files to the decoder: a short hand-written sequence that
// covers the header limits and each error, then random files that are mostly
// well formed. A behavioral decoder inside the bench predicts every result,
// and a monitor compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import bpd_pkg::*;

   // Number of input bytes that the random part aims for; the last file
   // may run past it.
   localparam int RANDOM_ITEMS = 335;
   // The run is cut off after this many clock cycles.
   localparam int CYCLE_LIMIT  = 1000000;
   // Length of the one long hold-off on the result channel.
   localparam int LONG_HOLD    = 400;
   // Cycles allowed after the last expected result for stray results.
   localparam int DRAIN_CYCLES = 400;
   // Mismatch reports beyond this count are counted but not printed.
   localparam int REPORT_CAP   = 20;
   localparam int PLAN_ROWS    = 25;

   // How the expected results of a hand-written row are obtained.
   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_NONE,
      ROW_ONE
   } row_kind_type;

   typedef struct packed {
      symbol_type   in_byte;
      logic         file_start;
      row_kind_type kind;
      literal_type  text;
      status_type   status;
   } plan_row_type;

   typedef struct packed {
      literal_type text;
      logic        last;
      status_type  status;
   } decoded_type;

   logic clock;
   logic reset;

   bpd_req_if req_ch ();
   bpd_rsp_if rsp_ch ();

   byte_pair_decoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // -------------------------------------------------------------------------
   // Behavioral decoder. It follows one input byte at a time and leaves the
   // results that the byte causes in fresh_q.
   // -------------------------------------------------------------------------
   phase_type     cur_phase;
   logic [6:0]    cur_count;
   logic [6:0]    cur_index;
   logic          half_seen;
   symbol_type    held;
   logic          in_error;
   pair_word_type pair_mem [PAIR_DEPTH];
   length_type    len_mem  [PAIR_DEPTH];

   decoded_type fresh_q [$];
   decoded_type expected_q [$];

   function automatic int symbol_length(input symbol_type s);
      return (s < 128) ? 1 : int'(len_mem[s[6:0]]);
   endfunction

   function automatic void raise_error(input status_type st);
      decoded_type r;
      in_error = 1'b1;
      r.text   = '0;
      r.last   = 1'b1;
      r.status = st;
      fresh_q.push_back(r);
   endfunction

   // Returns 0 when the byte is dropped because an error is pending.
   function automatic bit decode_byte(input symbol_type c, input logic fs);
      symbol_type    stk [STACK_DEPTH];
      int            sp;
      int            n;
      int            total;
      symbol_type    s;
      pair_word_type p;
      decoded_type   r;
      fresh_q.delete();
      if (fs) begin
         in_error  = 1'b0;
         cur_phase = PH_HEADER;
      end
      if (in_error)
         return 0;
      case (cur_phase)
         PH_TABLE: begin
            // A symbol may only name pairs that are already defined.
            if (c >= 128 && int'(c) - 128 >= int'(cur_index)) begin
               raise_error(STATUS_FWD_REF);
               return 1;
            end
            if (!half_seen) begin
               held      = c;
               half_seen = 1'b1;
               return 1;
            end
            total = symbol_length(held) + symbol_length(c);
            if (total > MAX_EXPANSION) begin
               raise_error(STATUS_TOO_LONG);
               return 1;
            end
            pair_mem[cur_index] = {held, c};
            len_mem[cur_index]  = total[LEN_W-1:0];
            half_seen = 1'b0;
            cur_index = cur_index + 7'd1;
            if (cur_index >= cur_count)
               cur_phase = PH_DATA;
         end
         PH_DATA: begin
            if (c < 128) begin
               r.text   = c[6:0];
               r.last   = 1'b1;
               r.status = STATUS_OK;
               fresh_q.push_back(r);
            end else if (int'(c) - 128 < int'(cur_count)) begin
               // Depth first walk: the first symbol of a pair is popped first.
               sp      = 1;
               n       = 0;
               stk[0]  = c;
               while (sp > 0 && n < MAX_EXPANSION) begin
                  sp = sp - 1;
                  s  = stk[sp];
                  if (s < 128) begin
                     r.text   = s[6:0];
                     r.last   = 1'b0;
                     r.status = STATUS_OK;
                     fresh_q.push_back(r);
                     n++;
                  end else begin
                     p = pair_mem[s[6:0]];
                     if (sp + 2 > STACK_DEPTH)
                        break;
                     stk[sp]     = p[7:0];
                     stk[sp + 1] = p[15:8];
                     sp          = sp + 2;
                  end
               end
               if (n > 0) begin
                  r      = fresh_q.pop_back();
                  r.last = 1'b1;
                  fresh_q.push_back(r);
               end
            end
         end
         default: begin
            if (c < 128 || int'(c) - 128 > MAX_PAIRS) begin
               raise_error(STATUS_BAD_HEADER);
               return 1;
            end
            cur_count = c[6:0];
            cur_index = '0;
            half_seen = 1'b0;
            held      = '0;
            cur_phase = (cur_count == 0) ? PH_DATA : PH_TABLE;
         end
      endcase
      return 1;
   endfunction

   // -------------------------------------------------------------------------
   // Shared bench state.
   // -------------------------------------------------------------------------
   row_kind_type row_kind;
   literal_type  row_text;
   status_type   row_status;

   bit gaps_on;
   int stall_orders;
   int stall_served;
   int hold_left;
   int decoded_items;
   int sent_items;
   int literal_results;
   int error_results;
   int fail_count;
   int cycle_count;
   int files_sent;
   int gen_len [PAIR_DEPTH];

   // -------------------------------------------------------------------------
   // Monitor. Result transfers are checked first, since they always belong
   // to bytes accepted at earlier edges; then an input transfer at the same
   // edge is run through the behavioral decoder.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      decoded_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_ch.status == STATUS_OK)
               literal_results++;
            else
               error_results++;
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_CAP)
                  $display("%0t: result with nothing expected: byte %0d last %0b status %0d",
                           $time, rsp_ch.out_byte, rsp_ch.last, rsp_ch.status);
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.out_byte !== want.text || rsp_ch.last !== want.last ||
                   rsp_ch.status !== want.status) begin
                  fail_count++;
                  if (fail_count <= REPORT_CAP)
                     $display("%0t: expected %0d/%0b/%0d, got %0d/%0b/%0d (byte/last/status)",
                              $time, want.text, want.last, want.status,
                              rsp_ch.out_byte, rsp_ch.last, rsp_ch.status);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (decode_byte(req_ch.in_byte, req_ch.file_start))
               decoded_items++;
            // Hand-written rows may carry their own expectation; the decoder
            // still runs so that its state stays in step with the unit.
            case (row_kind)
               ROW_MODEL: begin
                  foreach (fresh_q[i])
                     expected_q.push_back(fresh_q[i]);
               end
               ROW_ONE: begin
                  want.text   = row_text;
                  want.last   = 1'b1;
                  want.status = row_status;
                  expected_q.push_back(want);
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results still outstanding",
                  cycle_count, expected_q.size());
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Result side. It stalls at random while gaps are on, and serves each
   // long hold-off that the stimulus orders by counting cycles on its own.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (stall_served != stall_orders) begin
         stall_served = stall_orders;
         hold_left    = LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 35);
      end
   end

   // -------------------------------------------------------------------------
   // Input side. Each call is entered just after a falling edge, offers one
   // byte, and returns at the falling edge after the transfer. Valid stays
   // high into the next call, which either keeps it or opens a gap.
   // -------------------------------------------------------------------------
   task automatic offer_byte(input symbol_type b, input logic fs, input row_kind_type kind,
                             input literal_type text, input status_type st);
      while (gaps_on && $urandom_range(0, 99) < 35) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= b;
      req_ch.file_start <= fs;
      row_kind          <= kind;
      row_text          <= text;
      row_status        <= st;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send(input symbol_type b, input logic fs);
      offer_byte(b, fs, ROW_MODEL, '0, STATUS_OK);
   endtask

   // Literal count of a symbol within the file being generated.
   function automatic int gen_length(input symbol_type s);
      return (s < 128) ? 1 : gen_len[s[6:0]];
   endfunction

   // A table symbol for pair idx: a literal, or an earlier pair whose run
   // fits into the given budget of literals.
   function automatic symbol_type pick_symbol(input int idx, input int budget);
      symbol_type s;
      int         j;
      s = symbol_type'($urandom_range(0, 127));
      if (idx > 0 && $urandom_range(0, 99) < 50) begin
         for (int t = 0; t < 4; t++) begin
            j = $urandom_range(0, idx - 1);
            if (gen_len[j] <= budget) begin
               s = symbol_type'(128 + j);
               break;
            end
         end
      end
      return s;
   endfunction

   task automatic send_pair(input int idx, input symbol_type a, input symbol_type b);
      send(a, 1'b0);
      send(b, 1'b0);
      gen_len[idx] = gen_length(a) + gen_length(b);
   endtask

   // Data section: literals, defined codes (biased toward one code when a
   // favorite is given) and codes past the pair count.
   task automatic send_data(input int k, input int n, input int favorite);
      int r;
      for (int d = 0; d < n; d++) begin
         r = $urandom_range(0, 99);
         if (r < 40 || (r < 85 && k == 0) || (r >= 85 && k == 127))
            send(symbol_type'($urandom_range(0, 127)), 1'b0);
         else if (r < 85)
            send(symbol_type'((favorite >= 0 && $urandom_range(0, 1)) ? 128 + favorite
                                                 : 128 + $urandom_range(0, k - 1)),
                 1'b0);
         else
            send(symbol_type'(128 + $urandom_range(k, 127)), 1'b0);
      end
   endtask

   // Bytes after an error; the unit must drop them.
   task automatic send_junk();
      send(symbol_type'($urandom_range(0, 255)), 1'b0);
      send(symbol_type'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic send_random_file();
      int         kind;
      int         k;
      int         err_at;
      symbol_type a;
      symbol_type b;
      kind = $urandom_range(0, 99);
      files_sent++;
      if (kind < 55 || (kind >= 75 && kind < 87)) begin
         // Ordinary file, or one with a reference to an undefined pair.
         k      = (kind < 55) ? $urandom_range(0, 6) : $urandom_range(1, 6);
         err_at = (kind < 55) ? -1 : $urandom_range(0, k - 1);
         send(symbol_type'(128 + k), 1'b1);
         for (int i = 0; i < k; i++) begin
            a = pick_symbol(i, MAX_EXPANSION - 1);
            if (i == err_at) begin
               b = symbol_type'(128 + i + $urandom_range(0, 127 - i));
               if ($urandom_range(0, 1))
                  send(b, 1'b0);
               else begin
                  send(a, 1'b0);
                  send(b, 1'b0);
               end
               send_junk();
               return;
            end
            b = pick_symbol(i, MAX_EXPANSION - gen_length(a));
            send_pair(i, a, b);
         end
         send_data(k, $urandom_range(2, 12), -1);
      end else if (kind < 67) begin
         // Doubling pairs: a sixth pair, if any, expands to exactly the cap,
         // and a seventh, if any, pushes past it.
         k = $urandom_range(5, 7);
         send(symbol_type'(128 + k), 1'b1);
         send_pair(0, symbol_type'($urandom_range(0, 127)),
                   symbol_type'($urandom_range(0, 127)));
         for (int i = 1; i < k; i++) begin
            if (i == 6) begin
               send(symbol_type'(128 + 5), 1'b0);
               send($urandom_range(0, 1) ? 8'd133 : 8'($urandom_range(0, 127)), 1'b0);
               send_junk();
               return;
            end
            send_pair(i, symbol_type'(128 + i - 1), symbol_type'(128 + i - 1));
         end
         send_data(k, $urandom_range(2, 5), k - 1);
      end else if (kind < 75) begin
         // Chain of pairs, mostly nested on the left so the stack runs deep.
         k = $urandom_range(8, 63);
         send(symbol_type'(128 + k), 1'b1);
         send_pair(0, symbol_type'($urandom_range(0, 127)),
                   symbol_type'($urandom_range(0, 127)));
         for (int i = 1; i < k; i++) begin
            if ($urandom_range(0, 3) == 0)
               send_pair(i, symbol_type'($urandom_range(0, 127)),
                         symbol_type'(128 + i - 1));
            else
               send_pair(i, symbol_type'(128 + i - 1),
                         symbol_type'($urandom_range(0, 127)));
         end
         send_data(k, $urandom_range(2, 5), k - 1);
      end else begin
         // Noise, with file starts sprinkled in.
         k = $urandom_range(3, 10);
         for (int i = 0; i < k; i++)
            send(symbol_type'($urandom_range(0, 255)), $urandom_range(0, 99) < 25);
      end
   endtask

   function automatic plan_row_type plan_row(input symbol_type b, input logic fs,
                                             input row_kind_type kind, input literal_type text,
                                             input status_type st);
      plan_row_type r;
      r.in_byte    = b;
      r.file_start = fs;
      r.kind       = kind;
      r.text       = text;
      r.status     = st;
      return r;
   endfunction

   plan_row_type plan [PLAN_ROWS];

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.in_byte    = '0;
      req_ch.file_start = 1'b0;
      rsp_ch.ready      = 1'b0;
      row_kind          = ROW_NONE;
      row_text          = '0;
      row_status        = STATUS_OK;
      cur_phase         = PH_HEADER;
      cur_count         = '0;
      cur_index         = '0;
      half_seen         = 1'b0;
      held              = '0;
      in_error          = 1'b0;
      gaps_on           = 1'b1;
      stall_orders      = 0;
      stall_served      = 0;
      hold_left         = 0;
      decoded_items     = 0;
      sent_items        = 0;
      literal_results   = 0;
      error_results     = 0;
      fail_count        = 0;
      cycle_count       = 0;
      files_sent        = 0;

      // The first byte after reset is a header even without a file start,
      // so a literal there is a bad header. The following byte is dropped.
      plan[0]  = plan_row(8'h05, 1'b0, ROW_ONE,   7'd0,   STATUS_BAD_HEADER);
      plan[1]  = plan_row(8'h83, 1'b0, ROW_NONE,  7'd0,   STATUS_OK);
      // Largest pair count, abandoned at once by a new file with no pairs.
      plan[2]  = plan_row(8'hFF, 1'b1, ROW_NONE,  7'd0,   STATUS_OK);
      plan[3]  = plan_row(8'h80, 1'b1, ROW_NONE,  7'd0,   STATUS_OK);
      // Literal extremes pass straight through; any code is undefined here.
      plan[4]  = plan_row(8'h7F, 1'b0, ROW_ONE,   7'd127, STATUS_OK);
      plan[5]  = plan_row(8'h00, 1'b0, ROW_ONE,   7'd0,   STATUS_OK);
      plan[6]  = plan_row(8'h80, 1'b0, ROW_NONE,  7'd0,   STATUS_OK);
      // A pair that names itself in its second symbol.
      plan[7]  = plan_row(8'h81, 1'b1, ROW_NONE,  7'd0,   STATUS_OK);
      plan[8]  = plan_row(8'h41, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[9]  = plan_row(8'h80, 1'b0, ROW_ONE,   7'd0,   STATUS_FWD_REF);
      // Doubling pairs up to a run of exactly the cap, then one literal more.
      plan[10] = plan_row(8'h87, 1'b1, ROW_NONE,  7'd0,   STATUS_OK);
      plan[11] = plan_row(8'h7F, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[12] = plan_row(8'h00, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[13] = plan_row(8'h80, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[14] = plan_row(8'h80, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[15] = plan_row(8'h81, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[16] = plan_row(8'h81, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[17] = plan_row(8'h82, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[18] = plan_row(8'h82, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[19] = plan_row(8'h83, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[20] = plan_row(8'h83, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[21] = plan_row(8'h84, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[22] = plan_row(8'h84, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[23] = plan_row(8'h85, 1'b0, ROW_MODEL, 7'd0,   STATUS_OK);
      plan[24] = plan_row(8'h01, 1'b0, ROW_ONE,   7'd0,   STATUS_TOO_LONG);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++)
         offer_byte(plan[r].in_byte, plan[r].file_start, plan[r].kind,
                    plan[r].text, plan[r].status);

      // Random files until enough bytes have been sent. A few files in
      // are sent with no gaps on either side, and one early file meets a
      // long hold-off on the result channel so that the unit backs up.
      while (sent_items < PLAN_ROWS + RANDOM_ITEMS) begin
         gaps_on = !(files_sent >= 12 && files_sent < 20);
         if (files_sent == 5)
            stall_orders++;
         send_random_file();
      end
      req_ch.valid <= 1'b0;

      while (expected_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d random files; %0d bytes decoded, %0d literals and %0d errors returned.",
               files_sent, decoded_items, literal_results, error_results);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
